// ===== design/qte_pkg.sv =====
// qte_pkg: shared constants and the CORDIC arctangent table for the
// quaternion to Euler angle converter. No dependencies.
package qte_pkg;

  localparam int COMPONENT_WIDTH_DEF = 16;
  localparam int ANGLE_WIDTH_DEF     = 16;
  localparam int CORDIC_STAGES_DEF   = 16;

  localparam logic [31:0] TURN_QUARTER = 32'h4000_0000;

  // atan(2^-i) as a fraction of a full turn, scaled by 2^32
  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  function automatic logic [31:0] atan_turn(input int i);
    return ATAN_TURNS[i[4:0]];
  endfunction

  // right shift that brings a component product to 2^30 or less per unit
  function automatic int prod_shift(input int cw);
    return (2 * (cw - 2) > 30) ? (2 * (cw - 2) - 30) : 0;
  endfunction

endpackage

// ===== design/quaternion_to_euler_angles.sv =====
// quaternion_to_euler_angles: top level, quaternion in, roll/pitch/yaw out.
// Depends on qte_pkg, qte_front, qte_sqrt and qte_cordic.
//
// Usage:
//   Input channel quat_valid/quat_stall carries one quaternion (x, y, z, w),
//   signed Q2.(COMPONENT_WIDTH-2). Output channel euler_valid/euler_stall
//   carries roll, pitch and yaw as signed binary angles (half a turn is
//   2^(ANGLE_WIDTH-1)) plus pitch_saturated, set when the asin argument
//   was clamped to plus or minus one.
//   The pipeline holds two product/sum stages, the square root
//   (one stage per root bit plus square and subtract), the CORDIC stages
//   plus pre-rotation and rounding, and the output register.
//   Throughput is one transaction per cycle while euler_stall does not
//   hold the pipeline.
//   Reset clears every valid bit; no transaction is in flight afterwards.
//   When euler_stall is high with a result pending, the whole pipeline holds
//   and quat_stall is raised; nothing is dropped or repeated.
module quaternion_to_euler_angles import qte_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int ANGLE_WIDTH     = ANGLE_WIDTH_DEF,
  parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              quat_valid,
  output logic                              quat_stall,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_x,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_y,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_z,
  input  logic signed [COMPONENT_WIDTH-1:0] quat_w,
  output logic                              euler_valid,
  input  logic                              euler_stall,
  output logic signed [ANGLE_WIDTH-1:0]     roll_angle,
  output logic signed [ANGLE_WIDTH-1:0]     pitch_angle,
  output logic signed [ANGLE_WIDTH-1:0]     yaw_angle,
  output logic                              pitch_saturated
);

  localparam int CW     = COMPONENT_WIDTH;
  localparam int AW     = ANGLE_WIDTH;
  localparam int N      = CORDIC_STAGES;
  localparam int PW     = 2 * CW - prod_shift(CW);
  localparam int E      = PW - 4;
  localparam int SUM_W  = PW + 3;
  localparam int S_W    = E + 2;
  localparam int SQ_N   = E + 1;
  localparam int PASS_W = 4 * SUM_W + 1;
  localparam int NV     = SQ_N + N + 6;
  localparam logic signed [AW-1:0] QUARTER = {{(AW-1){1'b0}}, 1'b1} << (AW - 2);

  logic                    en;
  logic                    vld [0:NV-1];
  logic signed [SUM_W-1:0] num_r, den_r, num_y, den_y;
  logic signed [SUM_W-1:0] num_r_d, den_r_d, num_y_d, den_y_d;
  logic signed [S_W-1:0]   s_clamp;
  logic                    sat, sat_d;
  logic [PASS_W-1:0]       pass_out;
  logic [E:0]              root;
  logic [AW-1:0]           roll_raw, pitch_raw, yaw_raw;
  logic signed [AW-1:0]    pitch_next;
  logic                    sat_q [0:N+1];

  assign en         = !(euler_valid && euler_stall);
  assign quat_stall = !en;

  qte_front #(.CW(CW), .PW(PW), .E(E), .SUM_W(SUM_W), .S_W(S_W)) u_front (
    .clk     (clk),
    .en      (en),
    .quat_x  (quat_x),
    .quat_y  (quat_y),
    .quat_z  (quat_z),
    .quat_w  (quat_w),
    .num_r   (num_r),
    .den_r   (den_r),
    .num_y   (num_y),
    .den_y   (den_y),
    .s_clamp (s_clamp),
    .sat     (sat)
  );

  qte_sqrt #(.E(E), .S_W(S_W), .PASS_W(PASS_W)) u_sqrt (
    .clk      (clk),
    .en       (en),
    .s_in     (s_clamp),
    .pass_in  ({num_r, den_r, num_y, den_y, sat}),
    .root     (root),
    .pass_out (pass_out)
  );

  assign num_r_d = pass_out[PASS_W-1 -: SUM_W];
  assign den_r_d = pass_out[PASS_W-1-SUM_W -: SUM_W];
  assign num_y_d = pass_out[PASS_W-1-2*SUM_W -: SUM_W];
  assign den_y_d = pass_out[PASS_W-1-3*SUM_W -: SUM_W];
  assign sat_d   = pass_out[0];

  // s travels alongside the root through the square root pipe
  logic signed [S_W-1:0] s_q [0:SQ_N+1];
  always_ff @(posedge clk) begin
    if (en) begin
      s_q[0] <= s_clamp;
    end
  end
  for (genvar j = 0; j <= SQ_N; j++) begin : g_sdly
    always_ff @(posedge clk) begin
      if (en) begin
        s_q[j+1] <= s_q[j];
      end
    end
  end

  qte_cordic #(.IN_W(SUM_W), .N(N), .AW(AW)) u_roll (
    .clk   (clk),
    .en    (en),
    .y_in  (num_r_d),
    .x_in  (den_r_d),
    .angle (roll_raw)
  );

  qte_cordic #(.IN_W(S_W), .N(N), .AW(AW)) u_pitch (
    .clk   (clk),
    .en    (en),
    .y_in  (s_q[SQ_N+1]),
    .x_in  (S_W'(root)),
    .angle (pitch_raw)
  );

  qte_cordic #(.IN_W(SUM_W), .N(N), .AW(AW)) u_yaw (
    .clk   (clk),
    .en    (en),
    .y_in  (num_y_d),
    .x_in  (den_y_d),
    .angle (yaw_raw)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sat_q[0] <= sat_d;
    end
  end
  for (genvar j = 0; j <= N; j++) begin : g_satdly
    always_ff @(posedge clk) begin
      if (en) begin
        sat_q[j+1] <= sat_q[j];
      end
    end
  end

  always_comb begin
    pitch_next = $signed(pitch_raw);
    priority if ($signed(pitch_raw) > QUARTER) begin
      pitch_next = QUARTER;
    end else if ($signed(pitch_raw) < -QUARTER) begin
      pitch_next = -QUARTER;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_angle      <= $signed(roll_raw);
      pitch_angle     <= pitch_next;
      yaw_angle       <= $signed(yaw_raw);
      pitch_saturated <= sat_q[N+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      euler_valid <= 1'b0;
      for (int i = 0; i < NV; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= quat_valid;
      for (int i = 1; i < NV; i++) begin
        vld[i] <= vld[i-1];
      end
      euler_valid <= vld[NV-1];
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_clears: assert property (@(posedge clk) rst |=> !euler_valid)
    else $error("output valid after reset");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    euler_valid |-> (pitch_angle <= QUARTER) && (pitch_angle >= -QUARTER))
    else $error("pitch beyond a quarter turn");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !euler_valid |-> !quat_stall)
    else $error("input stalled with no pending transaction");
`endif

endmodule

// ===== design/qte_front.sv =====
// qte_front: component products (stage 1) and the atan2/asin arguments
// with asin clamping (stage 2). Depends on qte_pkg.
module qte_front import qte_pkg::*; #(
  parameter int CW    = COMPONENT_WIDTH_DEF,
  parameter int PW    = 2 * CW,
  parameter int E     = PW - 4,
  parameter int SUM_W = PW + 3,
  parameter int S_W   = E + 2
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CW-1:0]    quat_x,
  input  logic signed [CW-1:0]    quat_y,
  input  logic signed [CW-1:0]    quat_z,
  input  logic signed [CW-1:0]    quat_w,
  output logic signed [SUM_W-1:0] num_r,
  output logic signed [SUM_W-1:0] den_r,
  output logic signed [SUM_W-1:0] num_y,
  output logic signed [SUM_W-1:0] den_y,
  output logic signed [S_W-1:0]   s_clamp,
  output logic                    sat
);

  localparam logic signed [SUM_W-1:0] ONE_S = {{(SUM_W-1){1'b0}}, 1'b1} << E;

  logic signed [2*CW-1:0] f_wx, f_yz, f_xx, f_yy, f_xy, f_wz, f_zz, f_wy, f_xz;
  logic signed [PW-1:0]   p_wx, p_yz, p_xx, p_yy, p_xy, p_wz, p_zz, p_wy, p_xz;
  logic signed [SUM_W-1:0] nr, dr, ny, dy, s_raw, s_c;
  logic                    s_sat;

  assign f_wx = quat_w * quat_x;
  assign f_yz = quat_y * quat_z;
  assign f_xx = quat_x * quat_x;
  assign f_yy = quat_y * quat_y;
  assign f_xy = quat_x * quat_y;
  assign f_wz = quat_w * quat_z;
  assign f_zz = quat_z * quat_z;
  assign f_wy = quat_w * quat_y;
  assign f_xz = quat_x * quat_z;

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx <= f_wx[2*CW-1 -: PW];
      p_yz <= f_yz[2*CW-1 -: PW];
      p_xx <= f_xx[2*CW-1 -: PW];
      p_yy <= f_yy[2*CW-1 -: PW];
      p_xy <= f_xy[2*CW-1 -: PW];
      p_wz <= f_wz[2*CW-1 -: PW];
      p_zz <= f_zz[2*CW-1 -: PW];
      p_wy <= f_wy[2*CW-1 -: PW];
      p_xz <= f_xz[2*CW-1 -: PW];
    end
  end

  always_comb begin
    nr    = (SUM_W'(p_wx) + SUM_W'(p_yz)) <<< 1;
    dr    = ONE_S - ((SUM_W'(p_xx) + SUM_W'(p_yy)) <<< 1);
    ny    = (SUM_W'(p_xy) + SUM_W'(p_wz)) <<< 1;
    dy    = ONE_S - ((SUM_W'(p_yy) + SUM_W'(p_zz)) <<< 1);
    s_raw = (SUM_W'(p_wy) - SUM_W'(p_xz)) <<< 1;
    s_c   = s_raw;
    s_sat = 1'b0;
    priority if (s_raw > ONE_S) begin
      s_c   = ONE_S;
      s_sat = 1'b1;
    end else if (s_raw < -ONE_S) begin
      s_c   = -ONE_S;
      s_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r   <= nr;
      den_r   <= dr;
      num_y   <= ny;
      den_y   <= dy;
      s_clamp <= s_c[S_W-1:0];
      sat     <= s_sat;
    end
  end

endmodule

// ===== design/qte_sqrt.sv =====
// qte_sqrt: pipelined floor square root of one minus s squared, one result
// bit per stage, with a delayed side payload. Depends on qte_pkg.
module qte_sqrt import qte_pkg::*; #(
  parameter int E      = 28,
  parameter int S_W    = E + 2,
  parameter int PASS_W = 1
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [S_W-1:0] s_in,
  input  logic [PASS_W-1:0]     pass_in,
  output logic [E:0]            root,
  output logic [PASS_W-1:0]     pass_out
);

  localparam int R_W  = 2 * E + 2;
  localparam int SQ_N = E + 1;
  localparam logic [R_W-1:0] ONE_SQ = {{(R_W-1){1'b0}}, 1'b1} << (2 * E);

  logic signed [2*S_W-1:0] sq_full;
  logic [R_W-1:0]          sq;
  logic [R_W-1:0]          v [0:SQ_N];
  logic [R_W-1:0]          r [0:SQ_N];
  logic [PASS_W-1:0]       pass_q [0:SQ_N+1];

  assign sq_full = s_in * s_in;

  always_ff @(posedge clk) begin
    if (en) begin
      sq        <= sq_full[R_W-1:0];
      v[0]      <= ONE_SQ - sq;
      r[0]      <= '0;
      pass_q[0] <= pass_in;
    end
  end

  for (genvar k = 0; k < SQ_N; k++) begin : g_step
    localparam logic [R_W-1:0] BIT_K = {{(R_W-1){1'b0}}, 1'b1} << (2 * (E - k));
    logic [R_W-1:0] trial;
    assign trial = r[k] + BIT_K;
    always_ff @(posedge clk) begin
      if (en) begin
        if (v[k] >= trial) begin
          v[k+1] <= v[k] - trial;
          r[k+1] <= (r[k] >> 1) + BIT_K;
        end else begin
          v[k+1] <= v[k];
          r[k+1] <= r[k] >> 1;
        end
      end
    end
  end

  for (genvar j = 0; j <= SQ_N; j++) begin : g_pass
    always_ff @(posedge clk) begin
      if (en) begin
        pass_q[j+1] <= pass_q[j];
      end
    end
  end

  assign root     = r[SQ_N][E:0];
  assign pass_out = pass_q[SQ_N+1];

endmodule

// ===== design/qte_cordic.sv =====
// qte_cordic: pipelined vectoring CORDIC atan2 with quarter-turn
// pre-rotation and rounding to a binary angle. Depends on qte_pkg.
module qte_cordic import qte_pkg::*; #(
  parameter int IN_W = 34,
  parameter int N    = CORDIC_STAGES_DEF,
  parameter int AW   = ANGLE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic signed [IN_W-1:0] y_in,
  input  logic signed [IN_W-1:0] x_in,
  output logic [AW-1:0]          angle
);

  localparam int DW = IN_W + 2;
  localparam logic [63:0] HALF64 = (64'd1 << (32 - AW)) >> 1;
  localparam logic [31:0] HALF   = HALF64[31:0];

  logic signed [DW-1:0] xs [0:N];
  logic signed [DW-1:0] ys [0:N];
  logic [31:0]          zs [0:N];
  logic                 zf [0:N];
  logic signed [DW-1:0] xe, ye, x0, y0;
  logic [31:0]          z0, zr;

  always_comb begin
    xe = DW'(x_in);
    ye = DW'(y_in);
    x0 = xe;
    y0 = ye;
    z0 = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0 = ye;
        y0 = -xe;
        z0 = TURN_QUARTER;
      end else begin
        x0 = -ye;
        y0 = xe;
        z0 = -TURN_QUARTER;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= x0;
      ys[0] <= y0;
      zs[0] <= z0;
      zf[0] <= (x_in == '0) && (y_in == '0);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic [31:0] ATN = atan_turn(i);
    always_ff @(posedge clk) begin
      if (en) begin
        zf[i+1] <= zf[i];
        if (!ys[i][DW-1]) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + ATN;
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - ATN;
        end
      end
    end
  end

  assign zr = zs[N] + HALF;

  always_ff @(posedge clk) begin
    if (en) begin
      angle <= zf[N] ? '0 : zr[31 -: AW];
    end
  end

endmodule
